FILE: rtl/strp_pkg.sv
// Shared types and constants for the stream timestamp repair unit.
`timescale 1ns / 1ps

package strp_pkg;

    localparam logic [63:0] TS_MISSING   = 64'h8000_0000_0000_0000;
    localparam int          THR10_W      = 36;
    localparam int          THR100_W     = 39;
    localparam int          ADDR_W       = 4;
    localparam logic [31:0] DUR_RESET    = 32'd3000;
    localparam logic [THR10_W-1:0]  THR10_RESET  = 36'd30000;
    localparam logic [THR100_W-1:0] THR100_RESET = 39'd300000;

    typedef enum logic [1:0] {
        REG_UDP_MODE   = 2'd0,
        REG_STREAM_DUR = 2'd1,
        REG_NEXT_DUR   = 2'd2
    } t_reg_idx;

    typedef struct packed {
        logic                udp;
        logic [31:0]         sfd;
        logic [31:0]         nfd;
        logic [THR10_W-1:0]  thr10;
        logic [THR100_W-1:0] thr100;
    } t_cfg;

    typedef struct packed {
        logic        zero;
        logic        gen;
        logic        pv;
        logic        dv;
        logic [63:0] pts;
        logic [63:0] dts;
        logic [23:0] size;
        logic [63:0] pts_sfd;
        logic [63:0] pts_nfd;
    } t_item;

endpackage

FILE: rtl/stream_timestamp_repair_unit.sv
// Top level of the stream timestamp repair unit: register port, front end, queue, back end.
`timescale 1ns / 1ps

// An accepted packet beat is written into the queue, then loaded into the back end's output register.
// Throughput: one packet per cycle while the output is not stalled, set by the history update in the back end.
// The queue between front and back end holds QUEUE_DEPTH beats, so input and output stall
// independently. Synchronous active-low reset clears history, counters and the queue and
// returns the registers to datagram mode off and both frame durations to 3000.
module stream_timestamp_repair_unit #(
    parameter int QUEUE_DEPTH = 4
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_in_valid,
    output logic                        o_in_stall,
    input  logic                        i_pts_present,
    input  logic [63:0]                 i_pts_in,
    input  logic                        i_dts_present,
    input  logic [63:0]                 i_dts_in,
    input  logic [23:0]                 i_byte_count,
    output logic                        o_out_valid,
    input  logic                        i_out_stall,
    output logic                        o_accepted,
    output logic [63:0]                 o_pts_out,
    output logic [63:0]                 o_dts_out,
    output logic                        o_gap_detected,
    output logic                        o_gap_corrected,
    output logic [31:0]                 o_gap_total,
    output logic [31:0]                 o_frames_total,
    output logic [63:0]                 o_bytes_total,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [strp_pkg::ADDR_W-1:0] paddr,
    input  logic [31:0]                 pwdata,
    output logic [31:0]                 prdata,
    output logic                        pready
);
    import strp_pkg::*;

    logic                r_udp;
    logic [31:0]         r_sfd;
    logic [31:0]         r_nfd;
    logic [THR10_W-1:0]  r_thr10;
    logic [THR100_W-1:0] r_thr100;
    logic                wr_en;
    t_reg_idx            reg_idx;
    logic [THR10_W-1:0]  d10;
    logic [THR100_W-1:0] d100;
    t_cfg                cfg;
    t_item               front_item;
    t_item               queue_item;
    logic                queue_full;
    logic                queue_valid;
    logic                back_pop;

    assign pready  = 1'b1;
    assign wr_en   = psel && penable && pwrite && pready;
    assign reg_idx = t_reg_idx'(paddr[3:2]);
    assign d10     = {4'd0, pwdata};
    assign d100    = {7'd0, pwdata};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_udp    <= 1'b0;
            r_sfd    <= DUR_RESET;
            r_nfd    <= DUR_RESET;
            r_thr10  <= THR10_RESET;
            r_thr100 <= THR100_RESET;
        end else if (wr_en) begin
            case (reg_idx)
                REG_UDP_MODE: begin
                    r_udp <= pwdata[0];
                end
                REG_STREAM_DUR: begin
                    // Gap thresholds are ten and a hundred durations, formed by shifts.
                    r_sfd    <= pwdata;
                    r_thr10  <= (d10 << 3) + (d10 << 1);
                    r_thr100 <= (d100 << 6) + (d100 << 5) + (d100 << 2);
                end
                REG_NEXT_DUR: begin
                    r_nfd <= pwdata;
                end
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        case (reg_idx)
            REG_UDP_MODE:   prdata = {31'd0, r_udp};
            REG_STREAM_DUR: prdata = r_sfd;
            REG_NEXT_DUR:   prdata = r_nfd;
            default:        prdata = '0;
        endcase
    end

    always_comb begin
        cfg.udp    = r_udp;
        cfg.sfd    = r_sfd;
        cfg.nfd    = r_nfd;
        cfg.thr10  = r_thr10;
        cfg.thr100 = r_thr100;
    end

    assign o_in_stall = queue_full;

    strp_front u_front (
        .i_pts_present (i_pts_present),
        .i_pts_in      (i_pts_in),
        .i_dts_present (i_dts_present),
        .i_dts_in      (i_dts_in),
        .i_byte_count  (i_byte_count),
        .i_cfg         (cfg),
        .o_item        (front_item)
    );

    strp_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (i_in_valid),
        .i_data  (front_item),
        .o_full  (queue_full),
        .o_valid (queue_valid),
        .i_pop   (back_pop),
        .o_data  (queue_item)
    );

    strp_back u_back (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg           (cfg),
        .i_valid         (queue_valid),
        .i_item          (queue_item),
        .o_pop           (back_pop),
        .o_out_valid     (o_out_valid),
        .i_out_stall     (i_out_stall),
        .o_accepted      (o_accepted),
        .o_pts_out       (o_pts_out),
        .o_dts_out       (o_dts_out),
        .o_gap_detected  (o_gap_detected),
        .o_gap_corrected (o_gap_corrected),
        .o_gap_total     (o_gap_total),
        .o_frames_total  (o_frames_total),
        .o_bytes_total   (o_bytes_total)
    );

endmodule

FILE: rtl/strp_front.sv
// Front end: classifies an incoming packet beat and fills what needs no history.
`timescale 1ns / 1ps

module strp_front (
    input  logic           i_pts_present,
    input  logic [63:0]    i_pts_in,
    input  logic           i_dts_present,
    input  logic [63:0]    i_dts_in,
    input  logic [23:0]    i_byte_count,
    input  strp_pkg::t_cfg i_cfg,
    output strp_pkg::t_item o_item
);
    import strp_pkg::*;

    logic        pv0;
    logic        dv0;
    logic        pv;
    logic        dv;
    logic        gen;
    logic [63:0] pts;
    logic [63:0] dts;

    always_comb begin
        pv0 = i_pts_present && (i_pts_in != TS_MISSING);
        dv0 = i_dts_present && (i_dts_in != TS_MISSING);
        pv  = pv0;
        dv  = dv0;
        gen = 1'b0;
        pts = i_pts_in;
        dts = i_dts_in;
        if (i_cfg.udp) begin
            if (!pv0 && dv0) begin
                pts = i_dts_in;
                pv  = 1'b1;
            end else if (pv0 && !dv0) begin
                dts = i_pts_in;
                dv  = 1'b1;
            end else if (!pv0 && !dv0) begin
                gen = 1'b1;
            end
        end
        // A missing PTS is carried as the marker so the back end can store it directly.
        if (!pv) begin
            pts = TS_MISSING;
        end
    end

    always_comb begin
        o_item.zero    = (i_byte_count == 24'd0);
        o_item.gen     = gen;
        o_item.pv      = pv;
        o_item.dv      = dv;
        o_item.pts     = pts;
        o_item.dts     = dts;
        o_item.size    = i_byte_count;
        o_item.pts_sfd = pts + {32'd0, i_cfg.sfd};
        o_item.pts_nfd = pts + {32'd0, i_cfg.nfd};
    end

endmodule

FILE: rtl/strp_queue.sv
// Short queue between the front end and the back end.
`timescale 1ns / 1ps

module strp_queue #(
    parameter int DEPTH = 4
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  strp_pkg::t_item i_data,
    output logic            o_full,
    output logic            o_valid,
    input  logic            i_pop,
    output strp_pkg::t_item o_data
);
    import strp_pkg::*;

    localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    t_item             r_mem [DEPTH];
    logic [IDX_W-1:0]  r_wr;
    logic [IDX_W-1:0]  r_rd;
    logic [CNT_W-1:0]  r_count;
    logic              do_push;
    logic              do_pop;

    assign o_full  = (r_count == CNT_W'(DEPTH));
    assign o_valid = (r_count != '0);
    assign o_data  = r_mem[r_rd];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (do_push) begin
                r_wr <= (r_wr == IDX_W'(DEPTH - 1)) ? '0 : r_wr + 1'b1;
            end
            if (do_pop) begin
                r_rd <= (r_rd == IDX_W'(DEPTH - 1)) ? '0 : r_rd + 1'b1;
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + 1'b1;
            end else if (do_pop && !do_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(DEPTH))
        else $error("queue fill count exceeds depth");

endmodule

FILE: rtl/strp_back.sv
// Back end: history-dependent repair, gap checks, counters and the output register.
`timescale 1ns / 1ps

module strp_back (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  strp_pkg::t_cfg  i_cfg,
    input  logic            i_valid,
    input  strp_pkg::t_item i_item,
    output logic            o_pop,
    output logic            o_out_valid,
    input  logic            i_out_stall,
    output logic            o_accepted,
    output logic [63:0]     o_pts_out,
    output logic [63:0]     o_dts_out,
    output logic            o_gap_detected,
    output logic            o_gap_corrected,
    output logic [31:0]     o_gap_total,
    output logic [31:0]     o_frames_total,
    output logic [63:0]     o_bytes_total
);
    import strp_pkg::*;

    // History: previous PTS and the two sums derived from it.
    logic [63:0] r_prev;
    logic [63:0] r_pred;
    logic [63:0] r_gen;
    logic        r_prev_ok;
    logic [31:0] r_gap;
    logic [31:0] r_frames;
    logic [63:0] r_bytes;
    logic        r_out_valid;

    logic        load;
    logic        update;
    logic [63:0] sfd64;
    logic [63:0] nfd64;
    logic [63:0] pts_g;
    logic [63:0] gsfd;
    logic [63:0] gnfd;
    logic        pv_g;
    logic [63:0] pts_b;
    logic [63:0] dts_b;
    logic        pv_b;
    logic        dv_b;
    logic        ge;
    logic [63:0] diff;
    logic        check;
    logic        detected;
    logic        corrected;
    logic        pred_ok;
    logic [63:0] pts_c;
    logic [63:0] dts_c;
    logic        pv_c;
    logic        dv_c;
    logic [63:0] pts_o;
    logic [63:0] dts_o;
    logic [63:0] n_prev;
    logic [63:0] n_pred;
    logic [63:0] n_gen;
    logic [31:0] n_gap;
    logic [31:0] n_frames;
    logic [63:0] n_bytes;

    assign load   = i_valid && (!r_out_valid || !i_out_stall);
    assign update = load && !i_item.zero;
    assign o_pop  = load;
    assign sfd64  = {32'd0, i_cfg.sfd};
    assign nfd64  = {32'd0, i_cfg.nfd};

    always_comb begin
        pts_g = r_prev_ok ? r_gen : 64'd1;
        gsfd  = r_prev_ok ? (r_gen + sfd64) : (64'd1 + sfd64);
        gnfd  = r_prev_ok ? (r_gen + nfd64) : (64'd1 + nfd64);
        pv_g  = (pts_g != TS_MISSING);

        if (i_item.gen) begin
            pts_b = pts_g;
            dts_b = pts_g;
            pv_b  = pv_g;
            dv_b  = pv_g;
        end else begin
            pts_b = i_item.pts;
            dts_b = i_item.dts;
            pv_b  = i_item.pv;
            dv_b  = i_item.dv;
        end

        ge        = ($signed(pts_b) >= $signed(r_pred));
        diff      = ge ? (pts_b - r_pred) : (r_pred - pts_b);
        check     = i_cfg.udp && r_prev_ok && pv_b;
        detected  = check && (diff > {28'd0, i_cfg.thr10});
        corrected = check && (diff > {25'd0, i_cfg.thr100});
        pred_ok   = (r_pred != TS_MISSING);

        if (corrected) begin
            pts_c  = r_pred;
            dts_c  = r_pred;
            pv_c   = pred_ok;
            dv_c   = pred_ok;
            n_prev = r_pred;
            n_pred = r_pred + nfd64;
            n_gen  = r_pred + sfd64;
        end else begin
            pts_c  = pts_b;
            dts_c  = dts_b;
            pv_c   = pv_b;
            dv_c   = dv_b;
            n_prev = i_item.gen ? pts_g : i_item.pts;
            n_pred = i_item.gen ? gnfd : i_item.pts_nfd;
            n_gen  = i_item.gen ? gsfd : i_item.pts_sfd;
        end

        // Fill for the output only; history keeps the marker.
        pts_o = pts_c;
        dts_o = dts_c;
        if (!pv_c && dv_c) begin
            pts_o = dts_c;
        end else if (pv_c && !dv_c) begin
            dts_o = pts_c;
        end else if (!pv_c && !dv_c) begin
            pts_o = 64'd1;
            dts_o = 64'd1;
        end

        n_gap    = r_gap + {31'd0, detected};
        n_frames = r_frames + 32'd1;
        n_bytes  = r_bytes + {40'd0, i_item.size};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prev      <= '0;
            r_pred      <= '0;
            r_gen       <= '0;
            r_prev_ok   <= 1'b0;
            r_gap       <= '0;
            r_frames    <= '0;
            r_bytes     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (update) begin
                r_prev    <= n_prev;
                r_pred    <= n_pred;
                r_gen     <= n_gen;
                r_prev_ok <= (n_prev != TS_MISSING);
                r_gap     <= n_gap;
                r_frames  <= n_frames;
                r_bytes   <= n_bytes;
            end else begin
                // Keep the generated PTS in step with a newly written frame duration.
                r_gen <= r_prev + sfd64;
            end
            if (load) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            if (i_item.zero) begin
                o_accepted      <= 1'b0;
                o_pts_out       <= '0;
                o_dts_out       <= '0;
                o_gap_detected  <= 1'b0;
                o_gap_corrected <= 1'b0;
                o_gap_total     <= r_gap;
                o_frames_total  <= r_frames;
                o_bytes_total   <= r_bytes;
            end else begin
                o_accepted      <= 1'b1;
                o_pts_out       <= pts_o;
                o_dts_out       <= dts_o;
                o_gap_detected  <= detected;
                o_gap_corrected <= corrected;
                o_gap_total     <= n_gap;
                o_frames_total  <= n_frames;
                o_bytes_total   <= n_bytes;
            end
        end
    end

    assign o_out_valid = r_out_valid;

    a_frame_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_rst_n && update) |=> (r_frames == $past(r_frames) + 32'd1))
        else $error("frame count did not advance on an accepted packet");

    a_reject_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_rst_n && load && i_item.zero) |=>
            (r_bytes == $past(r_bytes)) && (r_pred == $past(r_pred)) && !o_accepted)
        else $error("rejected packet changed state");

    a_corrected_output: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && o_gap_corrected) |-> (o_gap_detected && (o_pts_out == o_dts_out)))
        else $error("corrected beat without detection or with differing timestamps");

endmodule

FILE: dv/tb.sv
// Self-checking testbench for the stream timestamp repair unit.
`timescale 1ns / 1ps

module tb;
    import strp_pkg::*;

    localparam int WATCHDOG_LIMIT  = 2000;
    localparam int TAIL_CYCLES     = 8;
    localparam int PHASE_PACKETS   = 275;
    localparam int PRINT_LIMIT     = 40;

    typedef struct packed {
        logic        accepted;
        logic [63:0] pts;
        logic [63:0] dts;
        logic        gap_detected;
        logic        gap_corrected;
        logic [31:0] gap_total;
        logic [31:0] frames_total;
        logic [63:0] bytes_total;
    } t_repair_result;

    logic                i_clk = 1'b0;
    logic                i_rst_n = 1'b0;
    logic                i_in_valid = 1'b0;
    logic                o_in_stall;
    logic                i_pts_present = 1'b0;
    logic [63:0]         i_pts_in = '0;
    logic                i_dts_present = 1'b0;
    logic [63:0]         i_dts_in = '0;
    logic [23:0]         i_byte_count = '0;
    logic                o_out_valid;
    logic                i_out_stall = 1'b0;
    logic                o_accepted;
    logic [63:0]         o_pts_out;
    logic [63:0]         o_dts_out;
    logic                o_gap_detected;
    logic                o_gap_corrected;
    logic [31:0]         o_gap_total;
    logic [31:0]         o_frames_total;
    logic [63:0]         o_bytes_total;
    logic                psel = 1'b0;
    logic                penable = 1'b0;
    logic                pwrite = 1'b0;
    logic [ADDR_W-1:0]   paddr = '0;
    logic [31:0]         pwdata = '0;
    logic [31:0]         prdata;
    logic                pready;

    // Register copy and stream history used for prediction.
    logic                cfg_udp = 1'b0;
    logic [31:0]         cfg_stream_dur = DUR_RESET;
    logic [31:0]         cfg_next_dur = DUR_RESET;
    logic [63:0]         hist_prev_pts = '0;
    logic [63:0]         hist_pred_pts = '0;
    logic                hist_seen_first = 1'b0;
    logic [31:0]         gap_count = '0;
    logic [31:0]         frame_count = '0;
    logic [63:0]         byte_total = '0;

    t_repair_result      expected_results[$];
    int                  mismatches = 0;
    int                  results_checked = 0;
    int                  packets_sent = 0;
    int                  packets_rejected = 0;
    int                  gaps_flagged = 0;
    int                  gaps_repaired = 0;
    int                  settings_used = 0;
    int                  send_idle_pct = 0;
    int                  recv_stall_pct = 0;
    int                  quiet_cycles = 0;

    stream_timestamp_repair_unit dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_stall     (o_in_stall),
        .i_pts_present  (i_pts_present),
        .i_pts_in       (i_pts_in),
        .i_dts_present  (i_dts_present),
        .i_dts_in       (i_dts_in),
        .i_byte_count   (i_byte_count),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .o_accepted     (o_accepted),
        .o_pts_out      (o_pts_out),
        .o_dts_out      (o_dts_out),
        .o_gap_detected (o_gap_detected),
        .o_gap_corrected(o_gap_corrected),
        .o_gap_total    (o_gap_total),
        .o_frames_total (o_frames_total),
        .o_bytes_total  (o_bytes_total),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .prdata         (prdata),
        .pready         (pready)
    );

    initial begin
        forever #6 i_clk = ~i_clk;
    end

    // Computes the repaired beat for one packet and, for a non-empty packet, advances the stream history.
    function automatic t_repair_result predict_repair(input logic pv_in,
                                                      input logic [63:0] pts_in,
                                                      input logic dv_in,
                                                      input logic [63:0] dts_in,
                                                      input logic [23:0] size);
        t_repair_result r;
        logic           pv;
        logic           dv;
        logic           prev_ok;
        logic [63:0]    pts;
        logic [63:0]    dts;
        logic [63:0]    dur;
        logic [63:0]    gap;

        r = '0;
        pts = pts_in;
        dts = dts_in;
        pv = pv_in && (pts_in != TS_MISSING);
        dv = dv_in && (dts_in != TS_MISSING);
        dur = {32'd0, cfg_stream_dur};
        packets_sent++;

        if (size == '0) begin
            packets_rejected++;
            r.gap_total = gap_count;
            r.frames_total = frame_count;
            r.bytes_total = byte_total;
            return r;
        end

        if (cfg_udp) begin
            prev_ok = hist_seen_first && (hist_prev_pts != TS_MISSING);
            if (!pv && dv) begin
                pts = dts;
                pv = 1'b1;
            end else if (pv && !dv) begin
                dts = pts;
                dv = 1'b1;
            end else if (!pv && !dv) begin
                pts = prev_ok ? hist_prev_pts + dur : 64'd1;
                dts = pts;
                pv = (pts != TS_MISSING);
                dv = pv;
            end
            if (prev_ok && pv) begin
                gap = ($signed(pts) >= $signed(hist_pred_pts)) ? pts - hist_pred_pts
                                                                : hist_pred_pts - pts;
                if (gap > dur * 64'd10) begin
                    r.gap_detected = 1'b1;
                    gap_count++;
                    gaps_flagged++;
                    if (gap > dur * 64'd100) begin
                        r.gap_corrected = 1'b1;
                        gaps_repaired++;
                        pts = hist_pred_pts;
                        dts = pts;
                        pv = (pts != TS_MISSING);
                        dv = pv;
                    end
                end
            end
        end

        hist_prev_pts = pv ? pts : TS_MISSING;
        hist_pred_pts = hist_prev_pts + {32'd0, cfg_next_dur};
        hist_seen_first = 1'b1;
        frame_count++;
        byte_total += {40'd0, size};

        // Output fill happens after the history update and never touches it.
        if (!pv && dv) begin
            pts = dts;
        end else if (pv && !dv) begin
            dts = pts;
        end else if (!pv && !dv) begin
            pts = 64'd1;
            dts = 64'd1;
        end

        r.accepted = 1'b1;
        r.pts = pts;
        r.dts = dts;
        r.gap_total = gap_count;
        r.frames_total = frame_count;
        r.bytes_total = byte_total;
        return r;
    endfunction

    task automatic report_mismatch(input string msg);
        if (mismatches < PRINT_LIMIT) begin
            $display("[%0t] mismatch on result %0d: %s", $realtime, results_checked, msg);
        end
        mismatches++;
    endtask

    task automatic compare_field(input string name, input logic [63:0] got,
                                 input logic [63:0] want);
        if (got !== want) begin
            report_mismatch($sformatf("%s got %h, expected %h", name, got, want));
        end
    endtask

    always @(posedge i_clk) begin
        t_repair_result want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (expected_results.size() == 0) begin
                report_mismatch("output beat with no packet pending");
            end else begin
                want = expected_results.pop_front();
                compare_field("accepted", 64'(o_accepted), 64'(want.accepted));
                compare_field("pts_out", o_pts_out, want.pts);
                compare_field("dts_out", o_dts_out, want.dts);
                compare_field("gap_detected", 64'(o_gap_detected), 64'(want.gap_detected));
                compare_field("gap_corrected", 64'(o_gap_corrected),
                              64'(want.gap_corrected));
                compare_field("gap_total", 64'(o_gap_total), 64'(want.gap_total));
                compare_field("frames_total", 64'(o_frames_total), 64'(want.frames_total));
                compare_field("bytes_total", o_bytes_total, want.bytes_total);
            end
            results_checked++;
        end
    end

    always @(posedge i_clk) begin
        i_out_stall <= i_rst_n && ($urandom_range(0, 99) < recv_stall_pct);
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall) || psel)
        begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin
        do @(posedge i_clk); while (quiet_cycles < WATCHDOG_LIMIT);
        $display("Timed out: no beat moved for %0d cycles, %0d results outstanding.",
                 WATCHDOG_LIMIT, expected_results.size());
        $display("FAIL stream_timestamp_repair_unit");
        $finish;
    end

    // Sends one packet beat, idling first at random, and records its expected result.
    task automatic send_packet(input logic pv, input logic [63:0] pts, input logic dv,
                               input logic [63:0] dts, input logic [23:0] size);
        t_repair_result want;
        while ($urandom_range(0, 99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_pts_present <= pv;
        i_pts_in <= pts;
        i_dts_present <= dv;
        i_dts_in <= dts;
        i_byte_count <= size;
        do @(posedge i_clk); while (o_in_stall);
        want = predict_repair(pv, pts, dv, dts, size);
        expected_results.push_back(want);
    endtask

    task automatic wait_for_drain();
        i_in_valid <= 1'b0;
        while (expected_results.size() != 0) @(posedge i_clk);
        repeat (2) @(posedge i_clk);
    endtask

    // Setup and access phase; the bus is left selected so writes can run back to back.
    task automatic write_reg(input t_reg_idx idx, input logic [31:0] value);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {idx, 2'b00};
        pwdata <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
    endtask

    // Setup and access phase of a read; the data is taken at the access edge.
    task automatic read_reg(input t_reg_idx idx, output logic [31:0] value);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b0;
        paddr <= {idx, 2'b00};
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        value = prdata;
    endtask

    task automatic check_reg(input t_reg_idx idx, input logic [31:0] want);
        logic [31:0] got;
        read_reg(idx, got);
        if (got !== want) begin
            report_mismatch($sformatf("register %s read %h, expected %h",
                                      idx.name(), got, want));
        end
    endtask

    task automatic apply_settings(input logic udp, input logic [31:0] stream_dur,
                                  input logic [31:0] next_dur);
        wait_for_drain();
        write_reg(REG_UDP_MODE, {31'd0, udp});
        write_reg(REG_STREAM_DUR, stream_dur);
        write_reg(REG_NEXT_DUR, next_dur);
        check_reg(REG_UDP_MODE, {31'd0, udp});
        check_reg(REG_STREAM_DUR, stream_dur);
        check_reg(REG_NEXT_DUR, next_dur);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        cfg_udp = udp;
        cfg_stream_dur = stream_dur;
        cfg_next_dur = next_dur;
        settings_used++;
    endtask

    // An empty packet before any history, then generation from nothing.
    task automatic test_udp_first_packet();
        apply_settings(1'b1, DUR_RESET, DUR_RESET);
        send_packet(1'b0, '0, 1'b0, '0, 24'd0);
        send_packet(1'b0, '0, 1'b0, '0, 24'd188);
    endtask

    task automatic test_udp_fill_rules();
        send_packet(1'b1, hist_pred_pts, 1'b0, '0, 24'd1);
        send_packet(1'b0, 64'hFFFF_FFFF_FFFF_FFFF, 1'b1, hist_pred_pts + 64'd5, 24'd1316);
        send_packet(1'b0, '0, 1'b0, '0, 24'd700);
        // A present timestamp equal to the marker counts as missing.
        send_packet(1'b1, TS_MISSING, 1'b1, hist_pred_pts, 24'd900);
    endtask

    task automatic test_udp_gap_thresholds();
        logic [63:0] thr;
        thr = {32'd0, cfg_stream_dur} * 64'd10;
        send_packet(1'b1, hist_pred_pts + thr, 1'b1, hist_pred_pts, 24'd400);
        send_packet(1'b1, hist_pred_pts + thr + 64'd1, 1'b1, hist_pred_pts, 24'd400);
        send_packet(1'b0, '0, 1'b0, '0, 24'd0);
        send_packet(1'b1, hist_pred_pts + thr * 64'd10, 1'b0, '0, 24'd400);
        send_packet(1'b1, hist_pred_pts - thr * 64'd10 - 64'd1, 1'b1, '0, 24'd400);
        send_packet(1'b1, 64'h7FFF_FFFF_FFFF_FFFF, 1'b1, 64'h8000_0000_0000_0001, 24'd1);
    endtask

    task automatic test_plain_mode();
        apply_settings(1'b0, DUR_RESET, DUR_RESET);
        send_packet(1'b1, 64'd90000, 1'b1, 64'd87000, 24'd1500);
        send_packet(1'b1, 64'd93000, 1'b0, 64'd5, 24'd1500);
        send_packet(1'b0, 64'd7, 1'b1, 64'd96000, 24'd1500);
        send_packet(1'b0, '0, 1'b0, '0, 24'hFF_FFFF);
        send_packet(1'b1, TS_MISSING, 1'b0, '0, 24'd1);
        send_packet(1'b1, 64'h8000_0000_0000_0001, 1'b1, 64'h7FFF_FFFF_FFFF_FFFF, 24'd2);
        send_packet(1'b0, '0, 1'b0, '0, 24'd0);
    endtask

    // Generated and predicted timestamps that wrap onto the missing marker.
    task automatic test_marker_wrap();
        send_packet(1'b1, TS_MISSING - {32'd0, cfg_stream_dur}, 1'b1, 64'd0, 24'd64);
        apply_settings(1'b1, DUR_RESET, DUR_RESET);
        send_packet(1'b0, '0, 1'b0, '0, 24'd64);
        send_packet(1'b0, '0, 1'b0, '0, 24'd64);
        apply_settings(1'b0, DUR_RESET, 32'd4500);
        send_packet(1'b1, TS_MISSING - 64'd4500, 1'b1, TS_MISSING - 64'd4500, 24'd64);
        apply_settings(1'b1, DUR_RESET, 32'd4500);
        send_packet(1'b1, 64'd0, 1'b0, '0, 24'd64);
    endtask

    // Mostly a continuing stream with jitter, mixed with gaps, noise and missing fields.
    task automatic send_random_packet();
        logic [63:0] dur;
        logic [63:0] mag;
        logic [63:0] noise;
        logic [63:0] pts;
        logic [63:0] dts;
        logic [23:0] size;
        logic        pv;
        logic        dv;
        int          pick;

        dur = {32'd0, cfg_stream_dur};
        noise = {$urandom, $urandom};
        pick = $urandom_range(0, 99);
        if (pick < 60) begin
            pts = hist_pred_pts + noise % (dur * 64'd4 + 64'd1) - dur * 64'd2;
        end else if (pick < 80) begin
            if (pick < 72) begin
                mag = dur * 64'd10 + 64'd1 + noise % (dur * 64'd90);
            end else begin
                mag = dur * 64'd100 + 64'd1 + noise % (dur * 64'd1000);
            end
            pts = $urandom_range(0, 1) ? hist_pred_pts + mag : hist_pred_pts - mag;
        end else if (pick < 88) begin
            pts = noise;
        end else if (pick < 93) begin
            pts = TS_MISSING;
        end else begin
            pts = 64'h7FFF_FFFF_FFFF_FFFF - noise % (dur * 64'd3);
        end

        pick = $urandom_range(0, 9);
        if (pick < 7) begin
            dts = pts - {$urandom, $urandom} % (dur * 64'd3 + 64'd1);
        end else if (pick == 7) begin
            dts = pts;
        end else if (pick == 8) begin
            dts = {$urandom, $urandom};
        end else begin
            dts = TS_MISSING;
        end

        pick = $urandom_range(0, 9);
        pv = (pick < 8);
        dv = (pick < 7) || (pick == 8);

        pick = $urandom_range(0, 99);
        if (pick < 3) begin
            size = '0;
        end else if (pick < 6) begin
            size = 24'hFF_FFFF;
        end else if (pick < 12) begin
            size = 24'($urandom);
        end else begin
            size = 24'($urandom_range(1, 4000));
        end
        send_packet(pv, pts, dv, dts, size);
    endtask

    task automatic test_random_traffic();
        for (int phase = 0; phase < 6; phase++) begin
            case (phase)
                0: begin
                    apply_settings(1'b1, 32'd1, 32'd1);
                end
                1: begin
                    apply_settings(1'b1, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
                end
                2: begin
                    apply_settings(1'b0, $urandom_range(1, 1000000), $urandom_range(1, 1000000));
                end
                3: begin
                    apply_settings(1'b1, DUR_RESET, 32'd3003);
                end
                4: begin
                    apply_settings(1'b1, $urandom_range(1, 100000), $urandom_range(1, 100000));
                end
                default: begin
                    apply_settings(1'($urandom), $urandom_range(1, 32'hFFFF_FFFF),
                                   $urandom_range(1, 32'hFFFF_FFFF));
                end
            endcase
            if (phase < 2) begin
                send_idle_pct = 34;
                recv_stall_pct = 56;
            end else if (phase < 4) begin
                send_idle_pct = 56;
                recv_stall_pct = 34;
            end else begin
                send_idle_pct = 0;
                recv_stall_pct = 0;
            end
            repeat (PHASE_PACKETS) send_random_packet();
        end
    endtask

    initial begin
        send_idle_pct = 34;
        recv_stall_pct = 56;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_udp_first_packet();
        test_udp_fill_rules();
        test_udp_gap_thresholds();
        test_plain_mode();
        test_marker_wrap();
        test_random_traffic();

        wait_for_drain();
        repeat (TAIL_CYCLES) @(posedge i_clk);

        $display("Checked %0d result beats for %0d packets: %0d empty, %0d gaps, %0d repaired.",
                 results_checked, packets_sent, packets_rejected, gaps_flagged, gaps_repaired);
        $display("Used %0d register settings under three idle patterns; %0d mismatches.",
                 settings_used, mismatches);
        if (mismatches == 0) begin
            $display("PASS stream_timestamp_repair_unit");
        end else begin
            $display("FAIL stream_timestamp_repair_unit");
        end
        $finish;
    end

endmodule

FILE: filelist.f
rtl/strp_pkg.sv
rtl/strp_front.sv
rtl/strp_queue.sv
rtl/strp_back.sv
rtl/stream_timestamp_repair_unit.sv
dv/tb.sv
